// ===== rtl/bedcl_pkg.sv =====
// Shared types and constants for the button debouncer with click latch.
// Used by the channel interfaces, the button table and the top level.
// No dependencies.
package bedcl_pkg;

  // Field widths of the request and response items.
  localparam int CMD_W    = 2;
  localparam int BUTTON_W = 3;
  localparam int TIME_W   = 32;
  localparam int MS_W     = 16;

  // Configuration port.
  localparam int REG_IDX_W = 1;
  localparam int CFG_DATA_W = MS_W;

  localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE   = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_CLICK_HOLD = 1'd1;

  localparam logic [MS_W-1:0] DEBOUNCE_RESET   = 16'd50;
  localparam logic [MS_W-1:0] CLICK_HOLD_RESET = 16'd1000;

  localparam int NUM_BUTTONS_DEFAULT = 8;

  // Request commands; the unused code behaves as a state read.
  localparam logic [CMD_W-1:0] CMD_EDGE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLICK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STATE = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [BUTTON_W-1:0] button;
    logic                level;
    logic [TIME_W-1:0]   now_ms;
  } req_t;

  typedef struct packed {
    logic              is_pressed;
    logic              click_seen;
    logic [TIME_W-1:0] press_time;
  } rsp_t;

  typedef struct packed {
    logic [MS_W-1:0] debounce_ms;
    logic [MS_W-1:0] click_hold_ms;
  } cfg_t;

endpackage

// ===== rtl/bedcl_if.sv =====
// Valid/ready channel interfaces for requests, responses and register writes.
// Depends on bedcl_pkg for the field widths.
interface bedcl_req_if;
  import bedcl_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [BUTTON_W-1:0] button;
  logic                level;
  logic [TIME_W-1:0]   now_ms;

  modport source (output valid, command, button, level, now_ms, input ready);
  modport sink   (input valid, command, button, level, now_ms, output ready);
endinterface

interface bedcl_rsp_if;
  import bedcl_pkg::*;
  logic              valid;
  logic              ready;
  logic              is_pressed;
  logic              click_seen;
  logic [TIME_W-1:0] press_time;

  modport source (output valid, is_pressed, click_seen, press_time, input ready);
  modport sink   (input valid, is_pressed, click_seen, press_time, output ready);
endinterface

interface bedcl_cfg_if;
  import bedcl_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [REG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ===== rtl/button_edge_debounce_click_latch.sv =====
// Top level of the time-lockout button debouncer with click latch.
// Depends on bedcl_pkg, the channel interfaces in bedcl_if and bedcl_table.
//
// This block debounces a table of NUM_BUTTONS buttons by locking out further
// changes of a button for debounce_ms milliseconds after each accepted change.
// Each request carries a command (edge event, read and clear click, or read
// state), a button index, a pin level and a millisecond timestamp, and gives
// exactly one response: the button's pressed flag after the request, whether
// a click query found a fresh click, and the press time while pressed. An
// accepted release latches a click, which a click query reports and clears
// only while it is at most click_hold_ms old. Indices at or above NUM_BUTTONS
// touch nothing and answer as a released button. A request is taken every
// clock cycle while the response channel does not stall; it is captured in
// an input register, and the addressed table entry is read, updated and
// written back when it moves on, together with the loading of the response
// register, which offers the response. That read-modify-write of the table
// sets the rate of one request per cycle, and because each request sees the
// state left by the one before it, back-to-back requests to the same button
// need no forwarding. Response back-pressure holds the pipeline in place.
// Registers are written through the configuration channel, which is always
// ready; they should be written only while no request is in flight. After
// reset all buttons are released with no click pending and all times zero.
module button_edge_debounce_click_latch #(
  parameter int NUM_BUTTONS = bedcl_pkg::NUM_BUTTONS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  bedcl_req_if.sink   req,
  bedcl_rsp_if.source rsp,
  bedcl_cfg_if.sink   cfg
);
  import bedcl_pkg::*;

  cfg_t cfg_regs;

  logic in_valid;
  req_t in_item;
  logic out_valid;
  rsp_t out_item;

  rsp_t result;
  logic advance;

  // The request in the input register moves on whenever the response
  // register is empty or is being emptied in this cycle.
  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      in_item.command <= req.command;
      in_item.button  <= req.button;
      in_item.level   <= req.level;
      in_item.now_ms  <= req.now_ms;
    end
  end

  // The table is updated in the same cycle that the response is loaded.
  bedcl_table #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_table (
    .clk    (clk),
    .rst    (rst),
    .load   (advance),
    .item   (in_item),
    .cfg    (cfg_regs),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.is_pressed = out_item.is_pressed;
  assign rsp.click_seen = out_item.click_seen;
  assign rsp.press_time = out_item.press_time;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.debounce_ms   <= DEBOUNCE_RESET;
      cfg_regs.click_hold_ms <= CLICK_HOLD_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        REG_DEBOUNCE:   cfg_regs.debounce_ms   <= cfg.wdata;
        REG_CLICK_HOLD: cfg_regs.click_hold_ms <= cfg.wdata;
        default: begin
          cfg_regs <= cfg_regs;
        end
      endcase
    end
  end

endmodule

// ===== rtl/bedcl_table.sv =====
// Per-button state table with its read-modify-write update.
// Depends on bedcl_pkg for the request, response and configuration types.
module bedcl_table #(
  parameter int NUM_BUTTONS = bedcl_pkg::NUM_BUTTONS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  bedcl_pkg::req_t  item,
  input  bedcl_pkg::cfg_t  cfg,
  output bedcl_pkg::rsp_t  result
);
  import bedcl_pkg::*;

  localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  logic                 pressed_flag  [NUM_BUTTONS];
  logic [TIME_W-1:0]    change_time   [NUM_BUTTONS];
  logic                 click_pending [NUM_BUTTONS];
  logic [TIME_W-1:0]    click_time    [NUM_BUTTONS];

  logic [BUTTON_W+IDX_W-1:0] button_wide;
  logic [IDX_W-1:0]          idx;
  logic                      in_range;

  logic              cur_pressed;
  logic [TIME_W-1:0] cur_change;
  logic              cur_pending;
  logic [TIME_W-1:0] cur_click;

  logic [TIME_W-1:0] since_change;
  logic [TIME_W-1:0] since_click;
  logic              edge_ok;
  logic              click_ok;

  logic              pressed_next;
  logic [TIME_W-1:0] change_next;
  logic              pending_next;
  logic [TIME_W-1:0] click_next;

  assign button_wide = {{IDX_W{1'b0}}, item.button};
  assign idx         = button_wide[IDX_W-1:0];
  assign in_range    = (32'(item.button) < 32'(NUM_BUTTONS));

  assign cur_pressed = pressed_flag[idx];
  assign cur_change  = change_time[idx];
  assign cur_pending = click_pending[idx];
  assign cur_click   = click_time[idx];

  assign since_change = item.now_ms - cur_change;
  assign since_click  = item.now_ms - cur_click;

  always_comb begin
    edge_ok  = 1'b0;
    click_ok = 1'b0;
    unique case (item.command)
      CMD_EDGE: begin
        // A high level only matters while pressed, a low level only while released.
        edge_ok = in_range && (item.level == cur_pressed) &&
                  (since_change > {{(TIME_W-MS_W){1'b0}}, cfg.debounce_ms});
      end
      CMD_CLICK: begin
        click_ok = in_range && cur_pending &&
                   !(since_click > {{(TIME_W-MS_W){1'b0}}, cfg.click_hold_ms});
      end
      default: begin
        edge_ok  = 1'b0;
        click_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    pressed_next = cur_pressed;
    change_next  = cur_change;
    pending_next = cur_pending;
    click_next   = cur_click;
    if (edge_ok) begin
      pressed_next = ~item.level;
      change_next  = item.now_ms;
      if (item.level) begin
        pending_next = 1'b1;
        click_next   = item.now_ms;
      end
    end else if (click_ok) begin
      pending_next = 1'b0;
      click_next   = '0;
    end
  end

  assign result.is_pressed = in_range && pressed_next;
  assign result.click_seen = click_ok;
  assign result.press_time = (in_range && pressed_next) ? change_next : '0;

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_entry
    always_ff @(posedge clk) begin
      if (rst) begin
        pressed_flag[i]  <= 1'b0;
        change_time[i]   <= '0;
        click_pending[i] <= 1'b0;
        click_time[i]    <= '0;
      end else if (load && in_range && (idx == IDX_W'(i))) begin
        pressed_flag[i]  <= pressed_next;
        change_time[i]   <= change_next;
        click_pending[i] <= pending_next;
        click_time[i]    <= click_next;
      end
    end
  end

endmodule
